// ----- sv/ttlx_pkg.sv -----
`default_nettype none
package ttlx_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int MAX_FIELD_EXPIRIES_DEF = 16;

  localparam logic [2:0] REQ_ADD    = 3'd0;
  localparam logic [2:0] REQ_APPEND = 3'd1;
  localparam logic [2:0] REQ_REMOVE = 3'd2;
  localparam logic [2:0] REQ_QUERY  = 3'd3;
  localparam logic [2:0] REQ_VERIFY = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EXISTS    = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_LIST_FULL = 3'd4;

  typedef enum logic [1:0] {
    DEC_NONE  = 2'd0,
    DEC_FALSE = 2'd1,
    DEC_TRUE  = 2'd2
  } dec_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_ITEM,
    S_MADDR,
    S_MCMP,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] doc_id;
    logic [62:0] time_sec;
    logic [29:0] time_nsec;
    logic [15:0] field_index;
    logic [6:0]  field_count;
    logic        predicate;
    logic        last_field;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       present;
    logic       doc_expired;
    logic       verify_valid;
    logic       verify_result;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic exec;
    logic item;
    logic merge_addr;
    logic merge_cmp;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic is_verify;
    logic item_skip;
    logic cur_end;
    logic slot_lt;
  } sts_t;

  // zero time never expires; otherwise expired when at or before now
  function automatic logic has_expired(input logic [62:0] s, input logic [29:0] ns,
                                       input logic [62:0] now_s, input logic [29:0] now_ns);
    logic r;
    if (s == '0 && ns == '0) r = 1'b0;
    else if (s > now_s) r = 1'b0;
    else if (s == now_s && ns > now_ns) r = 1'b0;
    else r = 1'b1;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/ttlx_dp.sv -----
`default_nettype none
module ttlx_dp #(
  parameter int TABLE_DEPTH = 64,
  parameter int MAX_FIELD_EXPIRIES = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ttlx_pkg::req_t req_i,
  input  wire ttlx_pkg::cmd_t cmd_i,
  output ttlx_pkg::sts_t      sts_o,
  output ttlx_pkg::rsp_t      rsp_o
);
  import ttlx_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(MAX_FIELD_EXPIRIES + 1);
  localparam int SD = TABLE_DEPTH * MAX_FIELD_EXPIRIES;
  localparam int SW = (SD > 1) ? $clog2(SD) : 1;

  typedef struct packed {
    logic [63:0] key;
    logic [62:0] sec;
    logic [29:0] nsec;
  } ent_t;

  typedef struct packed {
    logic [15:0] idx;
    logic [62:0] sec;
    logic [29:0] nsec;
  } slot_t;

  ent_t             ent_mem  [TABLE_DEPTH];
  logic [CW-1:0]    tot_mem  [TABLE_DEPTH];
  slot_t            slot_mem [SD];

  req_t             req_q;
  logic [TABLE_DEPTH-1:0] used_q;
  logic [IW-1:0]    cnt_q, rd_idx_q, hit_idx_q, free_idx_q, open_q;
  logic             rd_vld_q, found_q, free_vld_q;
  ent_t             ent_rd_q;
  logic [CW-1:0]    tot_rd_q, cap_tot_q, vtot_q, cur_q;
  logic [62:0]      cap_sec_q;
  logic [29:0]      cap_nsec_q;
  slot_t            slot_rd_q;
  logic             active_q, pred_q;
  dec_e             dec_q;
  logic [6:0]       seen_q, lim_q;
  rsp_t             rsp_q;

  logic             hit, last_rd, add_ok, app_ok, tot_we, slot_match;
  logic [IW-1:0]    tot_waddr;
  logic [CW-1:0]    tot_wdata, cur_inc;
  logic [SW-1:0]    slot_waddr, slot_raddr;

  function automatic rsp_t mk_rsp(input logic [2:0] st, input logic pr, input logic de,
                                  input logic vv, input logic vr);
    rsp_t r;
    r.status = st;
    r.present = pr;
    r.doc_expired = de;
    r.verify_valid = vv;
    r.verify_result = vr;
    return r;
  endfunction

  assign hit = rd_vld_q && used_q[rd_idx_q] && (ent_rd_q.key == req_q.doc_id);
  assign last_rd = (rd_idx_q == IW'(TABLE_DEPTH - 1));
  assign add_ok = cmd_i.exec && (req_q.req_type == REQ_ADD) && !found_q && free_vld_q;
  assign app_ok = cmd_i.exec && (req_q.req_type == REQ_APPEND) && found_q &&
                  (cap_tot_q < CW'(MAX_FIELD_EXPIRIES));
  assign tot_we = add_ok || app_ok;
  assign tot_waddr = add_ok ? free_idx_q : hit_idx_q;
  assign tot_wdata = add_ok ? '0 : cap_tot_q + CW'(1);
  assign slot_waddr = SW'(hit_idx_q) * SW'(MAX_FIELD_EXPIRIES) + SW'(cap_tot_q);
  assign slot_raddr = SW'(open_q) * SW'(MAX_FIELD_EXPIRIES) + SW'(cur_q);
  assign cur_inc = cur_q + CW'(1);
  assign slot_match = (has_expired(slot_rd_q.sec, slot_rd_q.nsec, req_q.time_sec,
                                   req_q.time_nsec) == pred_q);

  always_ff @(posedge clk_i) begin
    ent_rd_q  <= ent_mem[cnt_q];
    tot_rd_q  <= tot_mem[cnt_q];
    slot_rd_q <= slot_mem[slot_raddr];
    if (add_ok) begin
      ent_mem[free_idx_q] <= '{key: req_q.doc_id, sec: req_q.time_sec, nsec: req_q.time_nsec};
    end
    if (tot_we) begin
      tot_mem[tot_waddr] <= tot_wdata;
    end
    if (app_ok) begin
      slot_mem[slot_waddr] <= '{idx: req_q.field_index, sec: req_q.time_sec,
                                nsec: req_q.time_nsec};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0;
      used_q <= '0;
      cnt_q <= '0;
      rd_idx_q <= '0;
      hit_idx_q <= '0;
      free_idx_q <= '0;
      open_q <= '0;
      rd_vld_q <= 1'b0;
      found_q <= 1'b0;
      free_vld_q <= 1'b0;
      cap_tot_q <= '0;
      cap_sec_q <= '0;
      cap_nsec_q <= '0;
      vtot_q <= '0;
      cur_q <= '0;
      active_q <= 1'b0;
      pred_q <= 1'b0;
      dec_q <= DEC_NONE;
      seen_q <= '0;
      lim_q <= '0;
      rsp_q <= '0;
    end else begin
      if (cmd_i.load) begin
        req_q <= req_i;
        cnt_q <= '0;
        rd_vld_q <= 1'b0;
        found_q <= 1'b0;
        free_vld_q <= 1'b0;
        if (req_i.req_type != REQ_VERIFY) begin
          active_q <= 1'b0;
          dec_q <= DEC_NONE;
        end
      end
      if (cmd_i.scan) begin
        cnt_q <= cnt_q + IW'(1);
        rd_vld_q <= 1'b1;
        rd_idx_q <= cnt_q;
        if (hit) begin
          found_q <= 1'b1;
          hit_idx_q <= rd_idx_q;
          cap_sec_q <= ent_rd_q.sec;
          cap_nsec_q <= ent_rd_q.nsec;
          cap_tot_q <= tot_rd_q;
        end
        // first unused entry is where an add lands
        if (rd_vld_q && !used_q[rd_idx_q] && !free_vld_q) begin
          free_vld_q <= 1'b1;
          free_idx_q <= rd_idx_q;
        end
      end
      if (cmd_i.exec) begin
        case (req_q.req_type)
          REQ_ADD: begin
            if (found_q) begin
              rsp_q <= mk_rsp(ST_EXISTS, 1'b1, 1'b0, 1'b0, 1'b0);
            end else if (!free_vld_q) begin
              rsp_q <= mk_rsp(ST_FULL, 1'b0, 1'b0, 1'b0, 1'b0);
            end else begin
              used_q[free_idx_q] <= 1'b1;
              rsp_q <= mk_rsp(ST_OK, 1'b1, 1'b0, 1'b0, 1'b0);
            end
          end
          REQ_APPEND: begin
            if (!found_q) rsp_q <= mk_rsp(ST_NOT_FOUND, 1'b0, 1'b0, 1'b0, 1'b0);
            else if (!app_ok) rsp_q <= mk_rsp(ST_LIST_FULL, 1'b1, 1'b0, 1'b0, 1'b0);
            else rsp_q <= mk_rsp(ST_OK, 1'b1, 1'b0, 1'b0, 1'b0);
          end
          REQ_REMOVE: begin
            if (!found_q) begin
              rsp_q <= mk_rsp(ST_NOT_FOUND, 1'b0, 1'b0, 1'b0, 1'b0);
            end else begin
              used_q[hit_idx_q] <= 1'b0;
              rsp_q <= mk_rsp(ST_OK, 1'b0, 1'b0, 1'b0, 1'b0);
            end
          end
          REQ_QUERY: begin
            if (!found_q) rsp_q <= mk_rsp(ST_NOT_FOUND, 1'b0, 1'b0, 1'b0, 1'b0);
            else rsp_q <= mk_rsp(ST_OK, 1'b1, has_expired(cap_sec_q, cap_nsec_q,
                                 req_q.time_sec, req_q.time_nsec), 1'b0, 1'b0);
          end
          REQ_VERIFY: begin
            rsp_q <= mk_rsp(ST_OK, found_q, 1'b0, 1'b0, 1'b0);
            if (!active_q) begin
              active_q <= 1'b1;
              seen_q <= '0;
              cur_q <= '0;
              pred_q <= req_q.predicate;
              lim_q <= req_q.field_count;
              open_q <= hit_idx_q;
              vtot_q <= cap_tot_q;
              if (!found_q || cap_tot_q == '0 ||
                  (({{(7 > CW ? 7 - CW : 0){1'b0}}, cap_tot_q} < req_q.field_count) &&
                   !req_q.predicate)) begin
                dec_q <= DEC_TRUE;
              end else begin
                dec_q <= DEC_NONE;
              end
            end
          end
          default: begin
            rsp_q <= mk_rsp(ST_OK, found_q, 1'b0, 1'b0, 1'b0);
          end
        endcase
      end
      if (cmd_i.item) begin
        seen_q <= seen_q + 7'd1;
      end
      if (cmd_i.merge_addr && cur_q >= vtot_q) begin
        dec_q <= DEC_FALSE;
      end
      if (cmd_i.merge_cmp) begin
        if (slot_rd_q.idx < req_q.field_index) begin
          cur_q <= cur_inc;
        end else if (slot_rd_q.idx == req_q.field_index) begin
          if (slot_match) begin
            dec_q <= DEC_TRUE;
          end else begin
            cur_q <= cur_inc;
            if (cur_inc >= vtot_q) dec_q <= DEC_FALSE;
          end
        end
      end
      if (cmd_i.finish && req_q.req_type == REQ_VERIFY && req_q.last_field) begin
        rsp_q <= mk_rsp(rsp_q.status, rsp_q.present, rsp_q.doc_expired, 1'b1,
                        dec_q == DEC_TRUE);
        active_q <= 1'b0;
        dec_q <= DEC_NONE;
      end
    end
  end

  always_comb begin
    sts_o.scan_done = rd_vld_q && (hit || last_rd);
    sts_o.is_verify = (req_q.req_type == REQ_VERIFY);
    sts_o.item_skip = (dec_q != DEC_NONE) || (seen_q >= lim_q);
    sts_o.cur_end   = (cur_q >= vtot_q);
    sts_o.slot_lt   = (slot_rd_q.idx < req_q.field_index);
  end

  assign rsp_o = rsp_q;

  a_result_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_q.verify_result |-> rsp_q.verify_valid) else $error("result without valid");
  a_abort_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && req_i.req_type != REQ_VERIFY |=> !active_q)
    else $error("sequence not aborted");
  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> cur_q <= vtot_q) else $error("merge cursor past list");
  a_hit_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan && hit |=> found_q && used_q[hit_idx_q]) else $error("hit on free entry");

endmodule
`default_nettype wire

// ----- sv/ttlx_ctrl.sv -----
`default_nettype none
module ttlx_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  wire ttlx_pkg::sts_t sts_i,
  output ttlx_pkg::cmd_t      cmd_o,
  output logic                busy,
  output logic                done_o
);
  import ttlx_pkg::*;

  state_e state_q, state_d;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q <= (state_q == S_RESP);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start) state_d = S_SCAN;
      S_SCAN:  if (sts_i.scan_done) state_d = S_EXEC;
      S_EXEC:  state_d = sts_i.is_verify ? S_ITEM : S_RESP;
      S_ITEM:  state_d = sts_i.item_skip ? S_RESP : S_MADDR;
      S_MADDR: state_d = sts_i.cur_end ? S_RESP : S_MCMP;
      S_MCMP:  state_d = sts_i.slot_lt ? S_MADDR : S_RESP;
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:  cmd_o.load = start;
      S_SCAN:  cmd_o.scan = 1'b1;
      S_EXEC:  cmd_o.exec = 1'b1;
      S_ITEM:  cmd_o.item = !sts_i.item_skip;
      S_MADDR: cmd_o.merge_addr = 1'b1;
      S_MCMP:  cmd_o.merge_cmp = 1'b1;
      S_RESP:  cmd_o.finish = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  assign busy = (state_q != S_IDLE);
  assign done_o = done_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE) else $error("strobe while busy");
  a_start_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> state_q == S_SCAN) else $error("transfer not scanned");
  a_scan_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN && !sts_i.scan_done |=> state_q == S_SCAN)
    else $error("scan left early");

endmodule
`default_nettype wire

// ----- sv/ttl_table_expiry_check.sv -----
`default_nettype none
// Document expiry table. A request transfers when start is high and busy is low; one
// result follows on rsp_o for a single cycle marked by done_o, and it cannot be held
// off. Every request scans the key memory one entry per cycle, and the scan stops
// early when the key is found. A verify item adds an item step, plus a merge address
// and a merge compare step for each stored field expiry that the merge cursor
// compares, plus a further address step when the cursor runs past the field list.
module ttl_table_expiry_check #(
  parameter int TABLE_DEPTH = ttlx_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_FIELD_EXPIRIES = ttlx_pkg::MAX_FIELD_EXPIRIES_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire ttlx_pkg::req_t req_i,
  output logic                done_o,
  output ttlx_pkg::rsp_t      rsp_o
);
  import ttlx_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ttlx_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  ttlx_dp #(
    .TABLE_DEPTH        (TABLE_DEPTH),
    .MAX_FIELD_EXPIRIES (MAX_FIELD_EXPIRIES)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import ttlx_pkg::*;

  localparam int DEPTH = 64;
  localparam int FMAX = 16;
  localparam int NPOOL = 80;
  localparam int WATCH_LIMIT = 4000;
  localparam logic [62:0] SEC_MAX = {63{1'b1}};
  localparam logic [29:0] NS_TOP = 30'd999999999;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  rsp_t rsp_o;

  ttl_table_expiry_check u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .done_o(done_o), .rsp_o(rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the key table and field expiries
  logic        tbl_used [DEPTH];
  logic [63:0] tbl_key [DEPTH];
  logic [62:0] tbl_sec [DEPTH];
  logic [29:0] tbl_nsec [DEPTH];
  int          tbl_ftot [DEPTH];
  logic [15:0] fld_idx [DEPTH*FMAX];
  logic [62:0] fld_sec [DEPTH*FMAX];
  logic [29:0] fld_nsec [DEPTH*FMAX];
  int   chk_entry, chk_cursor, chk_seen, chk_count;
  dec_e chk_dec;
  logic chk_active, chk_pred;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  logic took = 1'b0;
  int   n_accepted = 0, n_results = 0, n_fail = 0, n_answers = 0, n_full = 0;
  int   watch = 0;
  logic [63:0] key_pool [NPOOL];

  function automatic logic expired_at(logic [62:0] s, logic [29:0] ns,
                                      logic [62:0] now_s, logic [29:0] now_ns);
    if (s == '0 && ns == '0) return 1'b0;
    if (s > now_s) return 1'b0;
    if (s == now_s && ns > now_ns) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int lookup(logic [63:0] k);
    for (int i = 0; i < DEPTH; i++)
      if (tbl_used[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void merge_item(req_t r);
    int tot, base, e;
    logic ex;
    if (!chk_active) begin
      e = lookup(r.doc_id);
      chk_active = 1'b1;
      chk_dec = DEC_NONE;
      chk_seen = 0;
      chk_cursor = 0;
      chk_pred = r.predicate;
      chk_count = r.field_count;
      if (e < 0) chk_dec = DEC_TRUE;
      else begin
        chk_entry = e;
        if (tbl_ftot[e] == 0) chk_dec = DEC_TRUE;
        else if (tbl_ftot[e] < chk_count && !chk_pred) chk_dec = DEC_TRUE;
      end
    end
    if (chk_dec != DEC_NONE || chk_seen >= chk_count) return;
    chk_seen++;
    tot = tbl_ftot[chk_entry];
    base = chk_entry * FMAX;
    while (chk_cursor < tot && fld_idx[base+chk_cursor] < r.field_index) chk_cursor++;
    if (chk_cursor >= tot) begin
      chk_dec = DEC_FALSE;
      return;
    end
    if (fld_idx[base+chk_cursor] == r.field_index) begin
      ex = expired_at(fld_sec[base+chk_cursor], fld_nsec[base+chk_cursor],
                      r.time_sec, r.time_nsec);
      if (ex == chk_pred) begin
        chk_dec = DEC_TRUE;
        return;
      end
      chk_cursor++;
      if (chk_cursor >= tot) chk_dec = DEC_FALSE;
    end
  endfunction

  function automatic rsp_t next_response(req_t r);
    rsp_t o;
    int e, f, s;
    o = '0;
    o.status = ST_OK;
    if (r.req_type != REQ_VERIFY) begin
      chk_active = 1'b0;
      chk_dec = DEC_NONE;
    end
    e = lookup(r.doc_id);
    case (r.req_type)
      REQ_ADD: begin
        if (e >= 0) o.status = ST_EXISTS;
        else begin
          f = -1;
          for (int i = 0; i < DEPTH; i++)
            if (!tbl_used[i] && f < 0) f = i;
          if (f < 0) begin
            o.status = ST_FULL;
            n_full++;
          end else begin
            tbl_used[f] = 1'b1;
            tbl_key[f] = r.doc_id;
            tbl_sec[f] = r.time_sec;
            tbl_nsec[f] = r.time_nsec;
            tbl_ftot[f] = 0;
          end
        end
      end
      REQ_APPEND: begin
        if (e < 0) o.status = ST_NOT_FOUND;
        else if (tbl_ftot[e] >= FMAX) o.status = ST_LIST_FULL;
        else begin
          s = e * FMAX + tbl_ftot[e];
          fld_idx[s] = r.field_index;
          fld_sec[s] = r.time_sec;
          fld_nsec[s] = r.time_nsec;
          tbl_ftot[e]++;
        end
      end
      REQ_REMOVE: begin
        if (e < 0) o.status = ST_NOT_FOUND;
        else tbl_used[e] = 1'b0;
      end
      REQ_QUERY: begin
        if (e < 0) o.status = ST_NOT_FOUND;
        else o.doc_expired = expired_at(tbl_sec[e], tbl_nsec[e], r.time_sec, r.time_nsec);
      end
      REQ_VERIFY: begin
        merge_item(r);
        if (r.last_field) begin
          o.verify_valid = 1'b1;
          o.verify_result = (chk_dec == DEC_TRUE);
          chk_active = 1'b0;
          chk_dec = DEC_NONE;
          n_answers++;
        end
      end
      default: ;
    endcase
    o.present = (lookup(r.doc_id) >= 0);
    return o;
  endfunction

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    rsp_t exp_r;
    if (rst_ni) begin
      took <= start && !busy;
      if (done_o) begin
        n_results++;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, rsp_o);
          n_fail++;
        end else begin
          exp_r = expected_rsps.pop_front();
          if (exp_r.status !== rsp_o.status || exp_r.present !== rsp_o.present ||
              exp_r.doc_expired !== rsp_o.doc_expired ||
              exp_r.verify_valid !== rsp_o.verify_valid ||
              exp_r.verify_result !== rsp_o.verify_result) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, exp_r, rsp_o);
            n_fail++;
          end
        end
      end
      if (start && !busy) begin
        expected_rsps.push_back(next_response(req_i));
        n_accepted++;
      end
      if ((start && !busy) || done_o) watch <= 0;
      else if (watch + 1 >= WATCH_LIMIT) begin
        $display("timeout after %0d quiet cycles", WATCH_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else watch <= watch + 1;
    end
  end

  // driver: hold a request until its transfer, idle at random between the first 400 requests
  always @(negedge clk_i) begin
    int idle_pct;
    idle_pct = (n_accepted < 200) ? 31 : (n_accepted < 400) ? 69 : 0;
    if (rst_ni && (!start || took)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        req_i <= pending_reqs.pop_front();
        start <= 1'b1;
      end else start <= 1'b0;
    end
  end

  task automatic push(logic [2:0] t, logic [63:0] k, logic [62:0] s, logic [29:0] ns,
                      logic [15:0] idx, logic [6:0] cnt, logic p, logic l);
    req_t r;
    r.req_type = t; r.doc_id = k; r.time_sec = s; r.time_nsec = ns;
    r.field_index = idx; r.field_count = cnt; r.predicate = p; r.last_field = l;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [62:0] pick_sec();
    int c;
    c = $urandom_range(99);
    if (c < 10) return '0;
    if (c < 85) return 63'(100 + $urandom_range(6));
    return 63'({$urandom, $urandom} >> 1);
  endfunction

  function automatic logic [29:0] pick_nsec();
    int c;
    c = $urandom_range(99);
    if (c < 20) return '0;
    if (c < 60) return 30'($urandom_range(3));
    if (c < 75) return NS_TOP;
    return 30'($urandom);
  endfunction

  function automatic logic [63:0] pick_key();
    if ($urandom_range(99) < 5) return {$urandom, $urandom};
    return key_pool[$urandom_range(NPOOL-1)];
  endfunction

  initial begin
    logic [63:0] k;
    logic [62:0] s;
    logic [29:0] ns;
    int c, cnt, n, idx, base_n;
    logic p;
    for (int i = 0; i < NPOOL; i++) key_pool[i] = {$urandom, $urandom};
    for (int i = 0; i < DEPTH; i++) begin
      tbl_used[i] = 1'b0;
      tbl_ftot[i] = 0;
    end
    chk_active = 1'b0; chk_dec = DEC_NONE; chk_pred = 1'b0;
    chk_entry = 0; chk_cursor = 0; chk_seen = 0; chk_count = 0;

    // directed: extremes, every request type and the corner cases
    push(REQ_ADD, '1, '0, '0, '0, '0, 0, 0);                 // never expires
    push(REQ_ADD, '1, 63'd7, 30'd1, '0, '0, 0, 1);           // key exists
    push(REQ_QUERY, '1, SEC_MAX, '1, '0, '0, 0, 0);
    push(REQ_ADD, '0, 63'd5, NS_TOP, '0, '0, 0, 0);
    push(REQ_QUERY, '0, 63'd5, NS_TOP, '0, '0, 0, 0);        // equal time has expired
    push(REQ_QUERY, '0, 63'd5, NS_TOP - 1, '0, '0, 0, 0);
    push(REQ_QUERY, '0, 63'd5, '1, '0, '0, 0, 0);            // nsec past one second
    push(REQ_APPEND, '0, 63'd10, '0, 16'd3, '0, 0, 0);
    push(REQ_APPEND, '0, '0, '0, 16'd7, '0, 0, 1);
    push(REQ_APPEND, '0, SEC_MAX, '1, '1, '1, 1, 1);
    push(REQ_APPEND, 64'd123, 63'd1, '0, '0, '0, 0, 0);      // missing key
    push(REQ_REMOVE, 64'd123, '0, '0, '0, '0, 0, 0);         // missing key
    push(REQ_VERIFY, '0, 63'd20, '0, 16'd3, 7'd2, 0, 0);
    push(REQ_VERIFY, '0, 63'd20, '0, 16'd7, 7'd2, 0, 1);
    push(REQ_VERIFY, '0, 63'd20, '0, 16'd3, 7'd1, 1, 1);
    push(REQ_VERIFY, 64'd123, '0, '0, '0, 7'd1, 1, 1);       // absent key
    push(REQ_ADD, 64'd9, 63'd1, '0, '0, '0, 0, 0);
    push(REQ_VERIFY, 64'd9, 63'd2, '0, '0, 7'd1, 1, 1);      // empty field list
    push(REQ_VERIFY, '0, 63'd2, '0, 16'd3, 7'd5, 0, 1);      // fewer stored than queried
    push(REQ_VERIFY, '0, 63'd2, '0, 16'd4, 7'd64, 1, 0);
    push(REQ_QUERY, '0, 63'd2, '0, '0, '0, 0, 0);            // aborts the sequence
    push(3'd5, '0, '0, '0, '0, '0, 0, 0);
    push(3'd6, '1, SEC_MAX, '1, '1, '1, 1, 1);
    push(3'd7, 64'd9, '0, '0, '0, '0, 0, 0);
    push(REQ_REMOVE, '1, '0, '0, '0, '0, 0, 0);
    push(REQ_QUERY, '1, '0, '0, '0, '0, 0, 0);

    // random: mostly well-formed append bursts and verify sequences
    base_n = pending_reqs.size();
    while (pending_reqs.size() < base_n + 600) begin
      c = $urandom_range(99);
      k = pick_key();
      if (c < 16) push(REQ_ADD, k, pick_sec(), pick_nsec(), 16'($urandom), 7'($urandom),
                       1'($urandom), 1'($urandom));
      else if (c < 34) begin
        n = ($urandom_range(9) == 0) ? 18 : $urandom_range(1, 5);
        idx = $urandom_range(12);
        for (int j = 0; j < n; j++) begin
          push(REQ_APPEND, k, pick_sec(), pick_nsec(), 16'(idx), 7'($urandom),
               1'($urandom), j == n - 1);
          idx += $urandom_range(3);
        end
      end else if (c < 44) push(REQ_REMOVE, k, pick_sec(), pick_nsec(), 16'($urandom),
                                7'($urandom), 1'($urandom), 1'($urandom));
      else if (c < 56) push(REQ_QUERY, k, pick_sec(), pick_nsec(), 16'($urandom),
                            7'($urandom), 1'($urandom), 1'($urandom));
      else if (c < 93) begin
        cnt = ($urandom_range(9) == 0) ? $urandom_range(0, 64) : $urandom_range(1, 6);
        n = cnt + (($urandom_range(9) == 0) ? 2 : 0);
        if ($urandom_range(9) == 0) n = $urandom_range(1, n + 1);
        if (n < 1) n = 1;
        if (n > 24) n = 24;
        idx = $urandom_range(10);
        s = 63'(100 + $urandom_range(6));
        ns = pick_nsec();
        p = 1'($urandom);
        for (int j = 0; j < n; j++) begin
          if (j > 0 && $urandom_range(39) == 0)
            push(REQ_QUERY, pick_key(), s, ns, '0, '0, 0, 0);  // broken sequence
          push(REQ_VERIFY, (j == 0) ? k : pick_key(), s, ns,
               ($urandom_range(19) == 0) ? 16'($urandom) : 16'(idx),
               (j == 0) ? 7'(cnt) : 7'($urandom), (j == 0) ? p : 1'($urandom), j == n - 1);
          idx += $urandom_range(3);
        end
      end else push(3'($urandom), k, 63'({$urandom, $urandom} >> 1), 30'($urandom),
                    16'($urandom), 7'($urandom), 1'($urandom), 1'($urandom));
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    wait (pending_reqs.size() == 0 && !start);
    wait (expected_rsps.size() == 0);
    repeat (300) @(posedge clk_i);
    if (expected_rsps.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_rsps.size());
      n_fail++;
    end
    $display("ran %0d requests, checked %0d results, %0d verify answers", n_accepted,
             n_results, n_answers);
    $display("table-full rejects seen: %0d, failures: %0d", n_full, n_fail);
    if (n_fail == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- ttl_table_expiry_check.f -----
sv/ttlx_pkg.sv
sv/ttlx_dp.sv
sv/ttlx_ctrl.sv
sv/ttl_table_expiry_check.sv
verif/testbench.sv
